### rtl/core/debounced_settings_writeback_top_defines.svh
// assertion macros for the debounced settings write-back block
`ifndef DEBOUNCED_SETTINGS_WRITEBACK_TOP_DEFINES_SVH
`define DEBOUNCED_SETTINGS_WRITEBACK_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent holds, consequent holds in the same cycle
`define DSW_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dsw check failed");

// antecedent holds, consequent holds in the next cycle
`define DSW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dsw check failed");

`else

`define DSW_ASSERT_SAME(lbl, clk, rst, ante, cons)

`define DSW_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/core/dsw_pkg.sv
// shared types and constants for the debounced settings write-back block
`default_nettype none

package dsw_pkg;

   localparam int TIME_BITS     = 32;
   localparam int LO_BITS       = 64;
   localparam int HI_BITS       = 34;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [TIME_BITS-1:0] SETTLE_TIME_RESET     = 32'd2000;
   localparam logic [TIME_BITS-1:0] BACKSTOP_PERIOD_RESET = 32'd60000;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_STORE_ENABLE    = 2'd0,
      CSR_SETTLE_TIME     = 2'd1,
      CSR_BACKSTOP_PERIOD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] now_time;
      logic [LO_BITS-1:0]   payload_lo;
      logic [HI_BITS-1:0]   payload_hi;
      logic                 write_ok;
   } req_payload_type;

   typedef struct packed {
      logic write_request;
      logic pending;
      logic in_sync;
   } rsp_payload_type;

endpackage

`default_nettype wire

### rtl/core/debounced_settings_writeback_top.sv
// top level of the debounced settings write-back block
`default_nettype none
`include "debounced_settings_writeback_top_defines.svh"

// One poll item is taken every cycle when the result side keeps up. Each item is
// registered on entry, judged against the committed and last seen payloads and the
// two timers, and its result registered once the result side has room, after which
// the result is offered on the result port. The state (payload copies, flags and
// timestamps) is updated together with the result register, so the next item always
// sees the effect of the one before. The committed and seen payload copies hold no
// reset value; they are only read while their valid flags are set. The user must
// write configuration through the csr port while no item is in flight; the block
// itself does not enforce this. An unknown register index is ignored.
module debounced_settings_writeback_top (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      req_valid,
   output logic                                     req_stall,
   input  wire  dsw_pkg::req_payload_type           req_payload,
   output logic                                     rsp_valid,
   input  wire                                      rsp_stall,
   output dsw_pkg::rsp_payload_type                 rsp_payload,
   input  wire                                      csr_write_enable,
   input  wire  [dsw_pkg::CSR_IDX_BITS-1:0]         csr_index,
   input  wire  [dsw_pkg::CSR_DATA_BITS-1:0]        csr_write_data
);

   // configuration
   logic                            store_enable_ff;
   logic [dsw_pkg::TIME_BITS-1:0]   settle_time_ff;
   logic [dsw_pkg::TIME_BITS-1:0]   backstop_period_ff;

   // pipeline
   logic                            s1_valid_ff;
   dsw_pkg::req_payload_type        s1_item_ff;
   logic                            rsp_valid_ff;
   dsw_pkg::rsp_payload_type        rsp_payload_ff;
   dsw_pkg::rsp_payload_type        rsp_payload_in;
   logic                            out_ready;
   logic                            s1_fire;

   // state
   logic [dsw_pkg::LO_BITS-1:0]     committed_lo_ff, committed_lo_in;
   logic [dsw_pkg::HI_BITS-1:0]     committed_hi_ff, committed_hi_in;
   logic [dsw_pkg::LO_BITS-1:0]     seen_lo_ff, seen_lo_in;
   logic [dsw_pkg::HI_BITS-1:0]     seen_hi_ff, seen_hi_in;
   logic                            committed_valid_ff, committed_valid_in;
   logic                            seen_valid_ff, seen_valid_in;
   logic                            change_waiting_ff, change_waiting_in;
   logic [dsw_pkg::TIME_BITS-1:0]   last_change_time_ff, last_change_time_in;
   logic [dsw_pkg::TIME_BITS-1:0]   last_commit_time_ff, last_commit_time_in;

   // decision terms
   logic                            differs_committed;
   logic                            moved;
   logic [dsw_pkg::TIME_BITS-1:0]   change_time;
   logic [dsw_pkg::TIME_BITS-1:0]   settle_elapsed;
   logic [dsw_pkg::TIME_BITS-1:0]   backstop_elapsed;
   logic                            settle_due;
   logic                            backstop_due;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && out_ready;
   assign req_stall = s1_valid_ff && !out_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign differs_committed = !committed_valid_ff
                              || (s1_item_ff.payload_lo != committed_lo_ff)
                              || (s1_item_ff.payload_hi != committed_hi_ff);
   assign moved = !seen_valid_ff
                  || (s1_item_ff.payload_lo != seen_lo_ff)
                  || (s1_item_ff.payload_hi != seen_hi_ff);
   assign change_time      = moved ? s1_item_ff.now_time : last_change_time_ff;
   assign settle_elapsed   = s1_item_ff.now_time - change_time;
   assign backstop_elapsed = s1_item_ff.now_time - last_commit_time_ff;
   assign settle_due       = settle_elapsed >= settle_time_ff;
   assign backstop_due     = backstop_elapsed >= backstop_period_ff;

   always_comb begin
      logic differs_now;
      logic settle_commit;
      logic req;
      committed_lo_in     = committed_lo_ff;
      committed_hi_in     = committed_hi_ff;
      seen_lo_in          = seen_lo_ff;
      seen_hi_in          = seen_hi_ff;
      committed_valid_in  = committed_valid_ff;
      seen_valid_in       = seen_valid_ff;
      change_waiting_in   = change_waiting_ff;
      last_change_time_in = last_change_time_ff;
      last_commit_time_in = last_commit_time_ff;
      differs_now         = differs_committed;
      settle_commit       = 1'b0;
      req                 = 1'b0;

      if (store_enable_ff) begin
         if (differs_committed) begin
            if (moved) begin
               seen_lo_in          = s1_item_ff.payload_lo;
               seen_hi_in          = s1_item_ff.payload_hi;
               seen_valid_in       = 1'b1;
               last_change_time_in = s1_item_ff.now_time;
               change_waiting_in   = 1'b1;
            end
            if (change_waiting_in && settle_due) begin
               req = 1'b1;
               if (s1_item_ff.write_ok) begin
                  settle_commit       = 1'b1;
                  committed_lo_in     = s1_item_ff.payload_lo;
                  committed_hi_in     = s1_item_ff.payload_hi;
                  committed_valid_in  = 1'b1;
                  last_commit_time_in = s1_item_ff.now_time;
                  change_waiting_in   = 1'b0;
                  differs_now         = 1'b0;
               end
            end
         end else begin
            change_waiting_in = 1'b0;
            seen_valid_in     = 1'b0;
         end

         // backstop write of a stale payload
         if (!change_waiting_in && !settle_commit && differs_now && backstop_due) begin
            req = 1'b1;
            if (s1_item_ff.write_ok) begin
               committed_lo_in     = s1_item_ff.payload_lo;
               committed_hi_in     = s1_item_ff.payload_hi;
               committed_valid_in  = 1'b1;
               last_commit_time_in = s1_item_ff.now_time;
               differs_now         = 1'b0;
            end
         end
      end

      rsp_payload_in.write_request = req;
      rsp_payload_in.pending       = change_waiting_in;
      rsp_payload_in.in_sync       = !differs_now;
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         store_enable_ff     <= 1'b0;
         settle_time_ff      <= dsw_pkg::SETTLE_TIME_RESET;
         backstop_period_ff  <= dsw_pkg::BACKSTOP_PERIOD_RESET;
         s1_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         committed_valid_ff  <= 1'b0;
         seen_valid_ff       <= 1'b0;
         change_waiting_ff   <= 1'b0;
         last_change_time_ff <= '0;
         last_commit_time_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               dsw_pkg::CSR_STORE_ENABLE:    store_enable_ff    <= csr_write_data[0];
               dsw_pkg::CSR_SETTLE_TIME:     settle_time_ff     <= csr_write_data;
               dsw_pkg::CSR_BACKSTOP_PERIOD: backstop_period_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (out_ready) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_fire) begin
            committed_valid_ff  <= committed_valid_in;
            seen_valid_ff       <= seen_valid_in;
            change_waiting_ff   <= change_waiting_in;
            last_change_time_ff <= last_change_time_in;
            last_commit_time_ff <= last_commit_time_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_item_ff <= req_payload;
      end
      if (s1_fire) begin
         rsp_payload_ff  <= rsp_payload_in;
         committed_lo_ff <= committed_lo_in;
         committed_hi_ff <= committed_hi_in;
         seen_lo_ff      <= seen_lo_in;
         seen_hi_ff      <= seen_hi_in;
      end
   end

   `DSW_ASSERT_NEXT(a_take_fills_stage, clock, reset, req_valid && !req_stall, s1_valid_ff)
   `DSW_ASSERT_NEXT(a_disabled_no_write, clock, reset,
                    s1_fire && !store_enable_ff, !rsp_payload_ff.write_request)
   `DSW_ASSERT_NEXT(a_sync_not_pending, clock, reset, s1_fire && store_enable_ff,
                    !(rsp_payload_ff.in_sync && rsp_payload_ff.pending))

endmodule

`default_nettype wire

### tb/debounced_settings_writeback_checker.sv
// poll predictor and result checker for the debounced settings write-back block
`timescale 1ns / 100ps

module debounced_settings_writeback_checker (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   input  wire                                req_stall,
   input  dsw_pkg::req_payload_type           req_payload,
   input  wire                                rsp_valid,
   input  wire                                rsp_stall,
   input  dsw_pkg::rsp_payload_type           rsp_payload,
   input  wire                                csr_write_enable,
   input  wire  [dsw_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire  [dsw_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   output int unsigned                        fail_count,
   output int unsigned                        items_in_flight,
   output int unsigned                        write_requests
);

   import dsw_pkg::*;

   logic                 store_on;
   logic [TIME_BITS-1:0] settle_limit;
   logic [TIME_BITS-1:0] backstop_limit;

   logic [LO_BITS-1:0]   flash_lo;
   logic [HI_BITS-1:0]   flash_hi;
   logic [LO_BITS-1:0]   moving_lo;
   logic [HI_BITS-1:0]   moving_hi;
   logic                 flash_valid;
   logic                 moving_valid;
   logic                 change_armed;
   logic [TIME_BITS-1:0] change_stamp;
   logic [TIME_BITS-1:0] commit_stamp;

   rsp_payload_type      poll_verdicts[$];
   rsp_payload_type      wanted;
   rsp_payload_type      fresh;
   int unsigned          mismatches = 0;
   int unsigned          requests_seen = 0;

   function automatic logic flash_stale(input logic [LO_BITS-1:0] lo,
                                        input logic [HI_BITS-1:0] hi);
      return !flash_valid || lo != flash_lo || hi != flash_hi;
   endfunction

   task automatic commit_payload(input req_payload_type poll);
      flash_lo     = poll.payload_lo;
      flash_hi     = poll.payload_hi;
      flash_valid  = 1'b1;
      commit_stamp = poll.now_time;
   endtask

   task automatic judge_poll(input req_payload_type poll, output rsp_payload_type verdict);
      logic                 fire;
      logic [TIME_BITS-1:0] since_change;
      logic [TIME_BITS-1:0] since_commit;
      fire = 1'b0;
      if (store_on) begin
         if (flash_stale(poll.payload_lo, poll.payload_hi)) begin
            if (!moving_valid || poll.payload_lo != moving_lo || poll.payload_hi != moving_hi) begin
               moving_lo    = poll.payload_lo;
               moving_hi    = poll.payload_hi;
               moving_valid = 1'b1;
               change_stamp = poll.now_time;
               change_armed = 1'b1;
            end
            since_change = poll.now_time - change_stamp;
            if (change_armed && since_change >= settle_limit) begin
               fire = 1'b1;
               if (poll.write_ok) begin
                  commit_payload(poll);
                  change_armed = 1'b0;
               end
            end
         end else begin
            change_armed = 1'b0;
            moving_valid = 1'b0;
         end
         since_commit = poll.now_time - commit_stamp;
         if (!change_armed && since_commit >= backstop_limit &&
             flash_stale(poll.payload_lo, poll.payload_hi)) begin
            fire = 1'b1;
            if (poll.write_ok) begin
               commit_payload(poll);
            end
         end
      end
      verdict.write_request = fire;
      verdict.pending       = change_armed;
      verdict.in_sync       = !flash_stale(poll.payload_lo, poll.payload_hi);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         store_on       = 1'b0;
         settle_limit   = SETTLE_TIME_RESET;
         backstop_limit = BACKSTOP_PERIOD_RESET;
         flash_valid    = 1'b0;
         moving_valid   = 1'b0;
         change_armed   = 1'b0;
         change_stamp   = '0;
         commit_stamp   = '0;
         poll_verdicts.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_STORE_ENABLE:    store_on       = csr_write_data[0];
               CSR_SETTLE_TIME:     settle_limit   = csr_write_data;
               CSR_BACKSTOP_PERIOD: backstop_limit = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            judge_poll(req_payload, fresh);
            poll_verdicts.push_back(fresh);
         end
         if (rsp_valid && !rsp_stall) begin
            if (rsp_payload.write_request === 1'b1) begin
               requests_seen++;
            end
            if (poll_verdicts.size() == 0) begin
               $error("result item with no poll waiting: %b", rsp_payload);
               mismatches++;
            end else begin
               wanted = poll_verdicts.pop_front();
               if (rsp_payload.write_request !== wanted.write_request) begin
                  $error("write_request mismatch: expected %0b, got %0b",
                         wanted.write_request, rsp_payload.write_request);
                  mismatches++;
               end
               if (rsp_payload.pending !== wanted.pending) begin
                  $error("pending mismatch: expected %0b, got %0b",
                         wanted.pending, rsp_payload.pending);
                  mismatches++;
               end
               if (rsp_payload.in_sync !== wanted.in_sync) begin
                  $error("in_sync mismatch: expected %0b, got %0b",
                         wanted.in_sync, rsp_payload.in_sync);
                  mismatches++;
               end
            end
         end
      end
      fail_count      <= mismatches;
      items_in_flight <= poll_verdicts.size();
      write_requests  <= requests_seen;
   end

endmodule

### tb/debounced_settings_writeback_top_tb.sv
// stimulus and verdict for the debounced settings write-back block
`timescale 1ns / 100ps

module debounced_settings_writeback_top_tb;

   import dsw_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam logic [TIME_BITS-1:0]    TIME_MAX         = 32'hFFFF_FFFF;
   localparam logic [LO_BITS-1:0]      LO_ONES          = '1;
   localparam logic [HI_BITS-1:0]      HI_ONES          = '1;

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   req_payload_type           req_payload      = '0;
   logic                      rsp_stall        = 1'b0;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_IDX_BITS-1:0]   csr_index        = '0;
   logic [CSR_DATA_BITS-1:0]  csr_write_data   = '0;

   logic                      req_stall;
   logic                      rsp_valid;
   rsp_payload_type           rsp_payload;

   int unsigned               fail_count;
   int unsigned               items_in_flight;
   int unsigned               write_requests;

   logic [TIME_BITS-1:0]      clock_ms   = '0;
   logic [TIME_BITS-1:0]      step_cap   = 32'd3;
   logic [LO_BITS-1:0]        cur_lo     = '0;
   logic [HI_BITS-1:0]        cur_hi     = '0;
   logic [LO_BITS-1:0]        recent_lo[4];
   logic [HI_BITS-1:0]        recent_hi[4];
   int                        burst_left = 0;
   int unsigned               polls_sent = 0;
   int unsigned               settings_used = 0;

   int                        stall_span = 0;
   int                        stall_mode = 0;
   logic [15:0]               stall_pattern = '0;

   debounced_settings_writeback_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   debounced_settings_writeback_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .items_in_flight  (items_in_flight),
      .write_requests   (write_requests)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("Test completed with failures");
      $finish;
   end

   // receiver back-pressure, independent of the sender
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode    = $urandom_range(0, 3);
         stall_span    = $urandom_range(8, 64);
         stall_pattern = 16'($urandom);
      end
      stall_span--;
      stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= stall_pattern[0];
         2: rsp_stall <= ($urandom_range(0, 9) != 0);
         default: rsp_stall <= stall_pattern[0] & stall_pattern[1];
      endcase
   end

   function automatic logic [HI_BITS-1:0] random_hi();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[HI_BITS-1:0];
   endfunction

   task automatic send_poll(input logic [TIME_BITS-1:0] stamp, input logic [LO_BITS-1:0] lo,
                            input logic [HI_BITS-1:0] hi, input logic ok);
      req_payload_type item;
      int              gap;
      item.now_time   = stamp;
      item.payload_lo = lo;
      item.payload_hi = hi;
      item.write_ok   = ok;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      polls_sent++;
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (items_in_flight != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_registers(input logic en, input logic [TIME_BITS-1:0] settle,
                                input logic [TIME_BITS-1:0] backstop);
      go_idle();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_STORE_ENABLE;
      csr_write_data   <= {{(CSR_DATA_BITS-1){1'b0}}, en};
      @(posedge clock);
      csr_index        <= CSR_SETTLE_TIME;
      csr_write_data   <= settle;
      @(posedge clock);
      csr_index        <= CSR_BACKSTOP_PERIOD;
      csr_write_data   <= backstop;
      @(posedge clock);
      // an index outside the map must leave everything alone
      csr_index        <= CSR_UNUSED_INDEX;
      csr_write_data   <= $urandom;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      step_cap = (settle >> 1) + (backstop >> 5) + 32'd3;
      settings_used++;
   endtask

   task automatic random_poll();
      int                   pick;
      int                   slot;
      int                   bit_pos;
      logic [TIME_BITS-1:0] delta;
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, 3);
      if (pick < 8) begin
         cur_lo = {$urandom, $urandom};
         cur_hi = random_hi();
         recent_lo[slot] = cur_lo;
         recent_hi[slot] = cur_hi;
      end else if (pick < 16) begin
         cur_lo = recent_lo[slot];
         cur_hi = recent_hi[slot];
      end else if (pick < 22) begin
         bit_pos = $urandom_range(0, LO_BITS + HI_BITS - 1);
         if (bit_pos < LO_BITS) begin
            cur_lo[bit_pos] = ~cur_lo[bit_pos];
         end else begin
            cur_hi[bit_pos - LO_BITS] = ~cur_hi[bit_pos - LO_BITS];
         end
         recent_lo[slot] = cur_lo;
         recent_hi[slot] = cur_hi;
      end
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
         delta = '0;
      end else if (pick == 2) begin
         delta = $urandom;
      end else begin
         delta = $urandom_range(0, step_cap);
      end
      clock_ms = clock_ms + delta;
      send_poll(clock_ms, cur_lo, cur_hi, $urandom_range(0, 7) != 0);
   endtask

   task automatic run_phase(input logic en, input logic [TIME_BITS-1:0] settle,
                            input logic [TIME_BITS-1:0] backstop, input int count);
      set_registers(en, settle, backstop);
      repeat (count) random_poll();
   endtask

   initial begin
      logic [LO_BITS-1:0] a_lo, b_lo, c_lo, d_lo;
      logic [HI_BITS-1:0] a_hi, b_hi, c_hi, d_hi;
      a_lo = {$urandom, $urandom};
      b_lo = {$urandom, $urandom};
      c_lo = {$urandom, $urandom};
      d_lo = {$urandom, $urandom};
      a_hi = random_hi();
      b_hi = random_hi();
      c_hi = random_hi();
      d_hi = random_hi();
      for (int i = 0; i < 4; i++) begin
         recent_lo[i] = {$urandom, $urandom};
         recent_hi[i] = random_hi();
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // storage off out of reset
      send_poll('0, LO_ONES, HI_ONES, 1'b1);
      send_poll(TIME_MAX, '0, '0, 1'b0);

      set_registers(1'b1, SETTLE_TIME_RESET, BACKSTOP_PERIOD_RESET);
      send_poll(32'd100, '0, '0, 1'b1);
      send_poll(32'd2099, '0, '0, 1'b1);
      send_poll(32'd2100, '0, '0, 1'b0);
      send_poll(32'd2101, '0, '0, 1'b1);
      send_poll(32'd2200, LO_ONES, HI_ONES, 1'b1);
      send_poll(32'd2300, '0, '0, 1'b1);
      send_poll(32'hFFFF_FF00, LO_ONES, HI_ONES, 1'b1);
      send_poll(32'h0000_0800, LO_ONES, HI_ONES, 1'b1);

      // storage off again, state still reported
      set_registers(1'b0, SETTLE_TIME_RESET, BACKSTOP_PERIOD_RESET);
      send_poll(32'h0000_0900, '0, '0, 1'b1);
      send_poll(32'h0000_0901, LO_ONES, HI_ONES, 1'b1);

      set_registers(1'b1, '0, TIME_MAX);
      send_poll(32'd5, a_lo, a_hi, 1'b1);
      send_poll(32'd6, b_lo, b_hi, 1'b0);
      send_poll(32'd7, b_lo, b_hi, 1'b1);

      set_registers(1'b1, TIME_MAX, '0);
      send_poll(32'd10, c_lo, c_hi, 1'b1);
      send_poll(32'd9, c_lo, c_hi, 1'b1);
      send_poll(32'd11, d_lo, d_hi, 1'b1);
      send_poll(32'd12, c_lo, c_hi, 1'b1);

      clock_ms = 32'd12;
      cur_lo   = c_lo;
      cur_hi   = c_hi;
      run_phase(1'b1, SETTLE_TIME_RESET, BACKSTOP_PERIOD_RESET, 300);
      run_phase(1'b1, '0, '0, 300);
      run_phase(1'b1, TIME_MAX, TIME_MAX, 200);
      run_phase(1'b1, 32'd3, 32'd17, 350);
      run_phase(1'b0, $urandom, $urandom, 60);
      run_phase(1'b1, $urandom_range(1, 50000), $urandom_range(0, 200000), 380);

      go_idle();
      repeat (10) @(posedge clock);
      $display("%0d polls sent under %0d register settings, %0d write requests seen",
               polls_sent, settings_used, write_requests);
      $display("storage off, failed and retried writes, resync, settle extremes, time wrap");
      if (fail_count == 0 && items_in_flight == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/dsw_pkg.sv
rtl/core/debounced_settings_writeback_top.sv
tb/debounced_settings_writeback_checker.sv
tb/debounced_settings_writeback_top_tb.sv
